[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RTNH_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtnh same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RTNH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtnh next-cycle check failed");

`endif

[rtl/rtnh_pkg.sv]
package rtnh_pkg;

  localparam int COORD_W   = 32;
  localparam int NCOORD    = 9;
  localparam int VEC_W     = COORD_W + 1;   // edge and offset components
  localparam int CRS_W     = 67;            // cross product components
  localparam int ACC_W     = 104;           // dot products
  localparam int DIV_W     = 136;           // shifted divisor and remainder
  localparam int T_W       = 31;
  localparam int UV_W      = 17;
  localparam int FACE_W    = 16;
  localparam int EPS_W     = 16;
  localparam int OP_W      = 5;
  localparam int NOPS      = 24;
  localparam int OUT_W     = 88;

  localparam logic [T_W-1:0] T_MAX = '1;

  localparam logic [1:0] CMD_ORG = 2'd0;
  localparam logic [1:0] CMD_DIR = 2'd1;
  localparam logic [1:0] CMD_TRI = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic CFG_EARLY = 1'b0;
  localparam logic CFG_EPS   = 1'b1;

  // Operand sources of the shared multiplier.
  localparam logic [4:0] SRC_DIR0 = 5'd0;
  localparam logic [4:0] SRC_TV0  = 5'd3;
  localparam logic [4:0] SRC_E1_0 = 5'd6;
  localparam logic [4:0] SRC_E2_0 = 5'd9;
  localparam logic [4:0] SRC_PV0  = 5'd12;
  localparam logic [4:0] SRC_QV0  = 5'd15;

  // Destinations of a finished accumulation.
  localparam logic [3:0] DST_PV0 = 4'd0;
  localparam logic [3:0] DST_QV0 = 4'd3;
  localparam logic [3:0] DST_DET = 4'd6;
  localparam logic [3:0] DST_UN  = 4'd7;
  localparam logic [3:0] DST_VN  = 4'd8;
  localparam logic [3:0] DST_TN  = 4'd9;

  typedef struct packed {
    logic [1:0]                      cmd;
    logic                            last;
    logic [NCOORD-1:0][COORD_W-1:0]  crd;
  } rtnh_item_t;

  typedef struct packed {
    logic [3:0] a_sel;
    logic [4:0] b_sel;
    logic [3:0] dst;
    logic       clr;
    logic       neg;
  } rtnh_op_t;

  function automatic rtnh_op_t mk_op(logic [4:0] a, logic [4:0] b, logic [3:0] d,
                                     logic c, logic n);
    rtnh_op_t o;
    o.a_sel = a[3:0];
    o.b_sel = b;
    o.dst   = d;
    o.clr   = c;
    o.neg   = n;
    return o;
  endfunction

  // Product sequence: pv = dir x e2, qv = tv x e1, then det, u, v and t numerators.
  function automatic rtnh_op_t op_rom(logic [OP_W-1:0] idx);
    rtnh_op_t o;
    case (idx)
      5'd0:  o = mk_op(SRC_DIR0 + 5'd1, SRC_E2_0 + 5'd2, DST_PV0,        1'b1, 1'b0);
      5'd1:  o = mk_op(SRC_DIR0 + 5'd2, SRC_E2_0 + 5'd1, DST_PV0,        1'b0, 1'b1);
      5'd2:  o = mk_op(SRC_DIR0 + 5'd2, SRC_E2_0,        DST_PV0 + 4'd1, 1'b1, 1'b0);
      5'd3:  o = mk_op(SRC_DIR0,        SRC_E2_0 + 5'd2, DST_PV0 + 4'd1, 1'b0, 1'b1);
      5'd4:  o = mk_op(SRC_DIR0,        SRC_E2_0 + 5'd1, DST_PV0 + 4'd2, 1'b1, 1'b0);
      5'd5:  o = mk_op(SRC_DIR0 + 5'd1, SRC_E2_0,        DST_PV0 + 4'd2, 1'b0, 1'b1);
      5'd6:  o = mk_op(SRC_TV0 + 5'd1,  SRC_E1_0 + 5'd2, DST_QV0,        1'b1, 1'b0);
      5'd7:  o = mk_op(SRC_TV0 + 5'd2,  SRC_E1_0 + 5'd1, DST_QV0,        1'b0, 1'b1);
      5'd8:  o = mk_op(SRC_TV0 + 5'd2,  SRC_E1_0,        DST_QV0 + 4'd1, 1'b1, 1'b0);
      5'd9:  o = mk_op(SRC_TV0,         SRC_E1_0 + 5'd2, DST_QV0 + 4'd1, 1'b0, 1'b1);
      5'd10: o = mk_op(SRC_TV0,         SRC_E1_0 + 5'd1, DST_QV0 + 4'd2, 1'b1, 1'b0);
      5'd11: o = mk_op(SRC_TV0 + 5'd1,  SRC_E1_0,        DST_QV0 + 4'd2, 1'b0, 1'b1);
      5'd12: o = mk_op(SRC_E1_0,        SRC_PV0,         DST_DET,        1'b1, 1'b0);
      5'd13: o = mk_op(SRC_E1_0 + 5'd1, SRC_PV0 + 5'd1,  DST_DET,        1'b0, 1'b0);
      5'd14: o = mk_op(SRC_E1_0 + 5'd2, SRC_PV0 + 5'd2,  DST_DET,        1'b0, 1'b0);
      5'd15: o = mk_op(SRC_TV0,         SRC_PV0,         DST_UN,         1'b1, 1'b0);
      5'd16: o = mk_op(SRC_TV0 + 5'd1,  SRC_PV0 + 5'd1,  DST_UN,         1'b0, 1'b0);
      5'd17: o = mk_op(SRC_TV0 + 5'd2,  SRC_PV0 + 5'd2,  DST_UN,         1'b0, 1'b0);
      5'd18: o = mk_op(SRC_DIR0,        SRC_QV0,         DST_VN,         1'b1, 1'b0);
      5'd19: o = mk_op(SRC_DIR0 + 5'd1, SRC_QV0 + 5'd1,  DST_VN,         1'b0, 1'b0);
      5'd20: o = mk_op(SRC_DIR0 + 5'd2, SRC_QV0 + 5'd2,  DST_VN,         1'b0, 1'b0);
      5'd21: o = mk_op(SRC_E2_0,        SRC_QV0,         DST_TN,         1'b1, 1'b0);
      5'd22: o = mk_op(SRC_E2_0 + 5'd1, SRC_QV0 + 5'd1,  DST_TN,         1'b0, 1'b0);
      5'd23: o = mk_op(SRC_E2_0 + 5'd2, SRC_QV0 + 5'd2,  DST_TN,         1'b0, 1'b0);
      default: o = mk_op(SRC_DIR0, SRC_DIR0, DST_DET, 1'b1, 1'b0);
    endcase
    return o;
  endfunction

endpackage

[rtl/rtnh_front.sv]
module rtnh_front (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [rtnh_pkg::NCOORD*rtnh_pkg::COORD_W-1:0] s_tdata,
  input  logic [1:0]                                 s_tuser,
  input  logic                                       s_tlast,
  output rtnh_pkg::rtnh_item_t                       item,
  output logic                                       item_valid,
  input  logic                                       item_ready
);

  logic full;

  assign s_tready   = !full || item_ready;
  assign item_valid = full;

  // Unused command codes are dropped here and never reach the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_tready) begin
      full <= s_tvalid && (s_tuser != rtnh_pkg::CMD_NOP);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.cmd  <= s_tuser;
      item.last <= s_tlast;
      item.crd  <= s_tdata;
    end
  end

endmodule

[rtl/rtnh_fifo.sv]
module rtnh_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  rtnh_pkg::rtnh_item_t in_item,
  input  logic                 in_valid,
  output logic                 in_ready,
  output rtnh_pkg::rtnh_item_t out_item,
  output logic                 out_valid,
  input  logic                 out_ready
);

  rtnh_pkg::rtnh_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

endmodule

[rtl/rtnh_back.sv]
module rtnh_back (
  input  logic                              clk,
  input  logic                              rst,
  input  rtnh_pkg::rtnh_item_t              item,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              early_exit,
  input  logic [rtnh_pkg::EPS_W-1:0]        epsilon,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rtnh_pkg::OUT_W-1:0]        m_tdata
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MLOAD = 4'd1;
  localparam logic [3:0] ST_MSTEP = 4'd2;
  localparam logic [3:0] ST_MWB   = 4'd3;
  localparam logic [3:0] ST_CHK1  = 4'd4;
  localparam logic [3:0] ST_NEG   = 4'd5;
  localparam logic [3:0] ST_CHK2  = 4'd6;
  localparam logic [3:0] ST_CHK3  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_UPD   = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  localparam logic [1:0] DSEL_T = 2'd0;
  localparam logic [1:0] DSEL_U = 2'd1;
  localparam logic [1:0] DSEL_V = 2'd2;

  localparam int ACC_W = rtnh_pkg::ACC_W;
  localparam int DIV_W = rtnh_pkg::DIV_W;
  localparam int VEC_W = rtnh_pkg::VEC_W;
  localparam int CRS_W = rtnh_pkg::CRS_W;
  localparam int T_W   = rtnh_pkg::T_W;
  localparam int UV_W  = rtnh_pkg::UV_W;

  logic [3:0] state;

  logic [rtnh_pkg::COORD_W-1:0] org  [3];
  logic [rtnh_pkg::COORD_W-1:0] dirr [3];

  logic signed [VEC_W-1:0] opa [12];   // dir, tv, e1, e2
  logic signed [CRS_W-1:0] pq  [6];    // pv, qv
  logic signed [ACC_W-1:0] det, un, vn, tn;
  logic signed [ACC_W-1:0] acc, bsh;
  logic [VEC_W-1:0]        amag;
  logic [rtnh_pkg::OP_W-1:0] op_idx;
  logic [5:0]              step;

  logic [DIV_W-1:0] rem, dsh;
  logic [T_W-1:0]   quo;
  logic [4:0]       dcnt;
  logic [1:0]       dsel;

  logic [T_W-1:0]  t_val;
  logic [UV_W-1:0] u_val;
  logic [rtnh_pkg::FACE_W-1:0] cur_face;
  logic                        cur_last;

  logic                        best_valid;
  logic [T_W-1:0]              best_t;
  logic [UV_W-1:0]             best_u, best_v;
  logic [rtnh_pkg::FACE_W-1:0] best_face, face_cnt;

  logic                        out_valid;
  logic [rtnh_pkg::OUT_W-1:0]  out_data;

  // Operand selection for the current multiplier op.
  rtnh_pkg::rtnh_op_t      op;
  logic signed [VEC_W-1:0] a_opd;
  logic signed [CRS_W-1:0] b_opd;
  logic signed [ACC_W-1:0] b_ext;
  logic signed [VEC_W-1:0] a_vert [9];

  // Checks on the normalized numerators.
  logic signed [ACC_W-1:0] eps_hi, eps_lo, uv_sum;
  logic [DIV_W-1:0]        tn_w, det_w, un_w, vn_w;
  logic                    div_ge;
  logic [T_W-1:0]          quo_next;

  assign op    = rtnh_pkg::op_rom(op_idx);
  assign a_opd = opa[op.a_sel];
  assign b_opd = (op.b_sel < rtnh_pkg::SRC_PV0)
               ? CRS_W'(opa[op.b_sel[3:0]])
               : pq[3'(op.b_sel - rtnh_pkg::SRC_PV0)];
  assign b_ext = ACC_W'(b_opd);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      a_vert[k] = VEC_W'($signed(item.crd[k]));
    end
  end

  assign eps_hi = $signed({{(ACC_W-rtnh_pkg::EPS_W-32){1'b0}}, epsilon, 32'b0});
  assign eps_lo = $signed(ACC_W'(64'h1_0000_0000)) - eps_hi;
  assign uv_sum = un + vn;
  assign tn_w   = DIV_W'($unsigned(tn));
  assign det_w  = DIV_W'($unsigned(det));
  assign un_w   = DIV_W'($unsigned(un));
  assign vn_w   = DIV_W'($unsigned(vn));

  assign div_ge   = (rem >= dsh);
  assign quo_next = {quo[T_W-2:0], div_ge};

  assign item_ready = (state == ST_IDLE);
  assign m_tvalid   = out_valid;
  assign m_tdata    = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      best_valid <= 1'b0;
      best_t     <= '0;
      best_u     <= '0;
      best_v     <= '0;
      best_face  <= '0;
      face_cnt   <= '0;
      out_valid  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        org[k]  <= '0;
        dirr[k] <= '0;
      end
    end else begin
      if (out_valid && m_tready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            case (item.cmd)
              rtnh_pkg::CMD_ORG: begin
                for (int k = 0; k < 3; k++) org[k] <= item.crd[k];
              end
              rtnh_pkg::CMD_DIR: begin
                for (int k = 0; k < 3; k++) dirr[k] <= item.crd[k];
              end
              rtnh_pkg::CMD_TRI: begin
                cur_face <= face_cnt;
                cur_last <= item.last;
                face_cnt <= face_cnt + 1'b1;
                for (int k = 0; k < 3; k++) begin
                  opa[k]     <= VEC_W'($signed(dirr[k]));
                  opa[3 + k] <= VEC_W'($signed(org[k])) - a_vert[k];
                  opa[6 + k] <= a_vert[3 + k] - a_vert[k];
                  opa[9 + k] <= a_vert[6 + k] - a_vert[k];
                end
                op_idx <= '0;
                state  <= (early_exit && best_valid) ? ST_FIN : ST_MLOAD;
              end
              default: begin
              end
            endcase
          end
        end

        ST_MLOAD: begin
          bsh   <= (op.neg ^ a_opd[VEC_W-1]) ? -b_ext : b_ext;
          amag  <= a_opd[VEC_W-1] ? VEC_W'(-a_opd) : VEC_W'(a_opd);
          if (op.clr) acc <= '0;
          step  <= '0;
          state <= ST_MSTEP;
        end

        ST_MSTEP: begin
          if (amag[0]) acc <= acc + bsh;
          bsh  <= bsh <<< 1;
          amag <= amag >> 1;
          step <= step + 6'd1;
          if (step == 6'(VEC_W - 1)) state <= ST_MWB;
        end

        ST_MWB: begin
          case (op.dst)
            rtnh_pkg::DST_DET: det <= acc;
            rtnh_pkg::DST_UN:  un  <= acc;
            rtnh_pkg::DST_VN:  vn  <= acc;
            rtnh_pkg::DST_TN:  tn  <= acc;
            default:           pq[3'(op.dst)] <= acc[CRS_W-1:0];
          endcase
          if (op_idx == rtnh_pkg::OP_W'(rtnh_pkg::NOPS - 1)) begin
            state <= ST_CHK1;
          end else begin
            op_idx <= op_idx + 1'b1;
            state  <= ST_MLOAD;
          end
        end

        ST_CHK1: begin
          // Reject a determinant of zero, or one whose Q16.16 value is within epsilon.
          if (det == '0 || (det >= eps_lo && det < eps_hi)) begin
            state <= ST_FIN;
          end else begin
            state <= ST_NEG;
          end
        end

        ST_NEG: begin
          if (det < 0) begin
            det <= -det;
            un  <= -un;
            vn  <= -vn;
            tn  <= -tn;
          end
          state <= ST_CHK2;
        end

        ST_CHK2: begin
          if (un < 0 || vn < 0 || tn < 0 || un > det) begin
            state <= ST_FIN;
          end else begin
            state <= ST_CHK3;
          end
        end

        ST_CHK3: begin
          if (uv_sum > det) begin
            state <= ST_FIN;
          end else if (tn_w >= (det_w << 15)) begin
            // Quotient would not fit in 31 bits: saturate and go on to u.
            t_val <= rtnh_pkg::T_MAX;
            rem   <= un_w << 16;
            dsh   <= det_w << 16;
            dcnt  <= 5'd16;
            dsel  <= DSEL_U;
            quo   <= '0;
            state <= ST_DIV;
          end else begin
            rem   <= tn_w << 16;
            dsh   <= det_w << 30;
            dcnt  <= 5'd30;
            dsel  <= DSEL_T;
            quo   <= '0;
            state <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_ge) rem <= rem - dsh;
          dsh  <= dsh >> 1;
          quo  <= quo_next;
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd0) begin
            quo <= '0;
            case (dsel)
              DSEL_T: begin
                t_val <= quo_next;
                if (quo_next <= T_W'(epsilon)) begin
                  state <= ST_FIN;
                end else begin
                  rem  <= un_w << 16;
                  dsh  <= det_w << 16;
                  dcnt <= 5'd16;
                  dsel <= DSEL_U;
                end
              end
              DSEL_U: begin
                u_val <= quo_next[UV_W-1:0];
                rem   <= vn_w << 16;
                dsh   <= det_w << 16;
                dcnt  <= 5'd16;
                dsel  <= DSEL_V;
              end
              default: begin
                // Last quotient is v; the hit is complete.
                if (!best_valid || t_val < best_t) begin
                  best_valid <= 1'b1;
                  best_t     <= t_val;
                  best_u     <= u_val;
                  best_v     <= quo_next[UV_W-1:0];
                  best_face  <= cur_face;
                end
                state <= ST_UPD;
              end
            endcase
          end
        end

        ST_UPD: begin
          state <= ST_FIN;
        end

        ST_FIN: begin
          if (!cur_last) begin
            state <= ST_IDLE;
          end else if (!out_valid) begin
            out_valid  <= 1'b1;
            out_data   <= {6'b0, best_face, best_v, best_u, best_t, best_valid};
            best_valid <= 1'b0;
            best_t     <= '0;
            best_u     <= '0;
            best_v     <= '0;
            best_face  <= '0;
            face_cnt   <= '0;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/ray_triangle_nearest_hit_top.sv]
// Channel    Direction  Signals                         Contents
// s_axis     in         s_tvalid/s_tready               ray loads and triangles
//                       s_tdata, s_tuser, s_tlast
// m_axis     out        m_tvalid/m_tready, m_tdata      one nearest-hit result per ray
// cfg        in         cfg_we, cfg_index, cfg_data     early_exit, epsilon
//
// An accepted item is registered in the input stage and then in the queue before the back
// sees it; a ray load is taken while the back is idle and does not leave the idle state.
// A tested triangle holds the back while it runs 24 products on one shift-add
// multiplier, the check states and the sign state, the t, u and v division and
// the control states; a rejection or an early exit ends sooner.
// Reset is synchronous. A stalled result waits in the output register while the back
// keeps working; only the next result waits for it, and the input stalls once the
// input stage and the two-entry queue are full.
module ray_triangle_nearest_hit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [287:0] s_tdata,   // ax, ay, az, bx, by, bz, cx, cy, cz (32 bits each)
  input  logic [1:0]  s_tuser,    // command
  input  logic        s_tlast,    // last_face
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,    // hit, hit_distance, bary_u, bary_v, hit_face, zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  rtnh_pkg::rtnh_item_t front_item, queue_item;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  logic        early_exit;
  logic [15:0] epsilon;

  // Configuration registers; written by the user only while the block is idle; unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      early_exit <= 1'b0;
      epsilon    <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        rtnh_pkg::CFG_EARLY: early_exit <= cfg_data[0];
        rtnh_pkg::CFG_EPS:   epsilon    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front stage registers each item and drops unused commands.
  rtnh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  // The queue lets the front keep taking items while the back is busy.
  rtnh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_item   (front_item),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_item  (queue_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready)
  );

  // The back holds the ray, runs the intersection test and keeps the nearest hit.
  rtnh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (queue_item),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .early_exit (early_exit),
    .epsilon    (epsilon),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

[rtl/rtnh_checker.sv]
`include "assert_macros.svh"

module rtnh_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata
);

  // A stalled result stays offered and unchanged.
  `RTNH_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
  `RTNH_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
  // A miss reports all fields as zero.
  `RTNH_ASSERT(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[87:1] == 87'd0)
  // Barycentric coordinates of a hit never exceed one.
  `RTNH_ASSERT(a_bary_u_range, m_tvalid && m_tdata[0], m_tdata[48:32] <= 17'h10000)
  `RTNH_ASSERT(a_bary_v_range, m_tvalid && m_tdata[0], m_tdata[65:49] <= 17'h10000)

endmodule

bind ray_triangle_nearest_hit_top rtnh_checker u_rtnh_checker (.*);

[bench/ray_triangle_nearest_hit_top_tb.sv]
// Self-checking bench for the ray-triangle nearest-hit unit. Rays and
// triangles stream in on the input side; the nearest-hit result of each ray
// is predicted in wide exact integers and compared field by field.
module ray_triangle_nearest_hit_top_tb;

  // Exact signed arithmetic wide enough for every product and quotient.
  typedef logic signed [191:0] wint_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              last;
    logic [8:0][31:0]  crd;   // ax, ay, az, bx, by, bz, cx, cy, cz from index 0
  } ray_item_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] hit_dist;
    logic [16:0] u;
    logic [16:0] v;
    logic [15:0] face;
  } hit_result_t;

  typedef int coord9_t[9];

  // Up to four triangles can still be in flight.
  localparam int SETTLE_CYCLES = 5000;
  localparam int STALL_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 188;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic [1:0]   s_tuser = rtnh_pkg::CMD_NOP;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [87:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = rtnh_pkg::CFG_EARLY;
  logic [15:0]  cfg_data = '0;

  ray_triangle_nearest_hit_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Pending stimulus and the results we still wait for, oldest first.
  ray_item_t   pending_items[$];
  hit_result_t nearest_hits[$];

  // Shadow copy of the block's state and registers.
  logic [31:0] ray_org[3];
  logic [31:0] ray_dir[3];
  logic        best_valid;
  logic [30:0] best_t;
  logic [16:0] best_u, best_v;
  logic [15:0] best_face, face_count;
  logic        early_exit_r;
  logic [15:0] epsilon_r;

  int  mismatches = 0;
  bit  calm = 0;           // when set, neither side idles
  bit  in_taken = 0, out_taken = 0;
  int  gap_left = 0, stall_left = 0;
  int  quiet_cycles = 0;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Moller-Trumbore test of one triangle against the current ray, done exactly.
  function automatic bit triangle_hit(input logic [8:0][31:0] crd, output logic [30:0] t_o,
                                      output logic [16:0] u_o, output logic [16:0] v_o);
    wint_t a[3], e1[3], e2[3], tv[3], d[3], pv[3], qv[3];
    wint_t det, un, vn, tn, hi, lo, tq;
    for (int k = 0; k < 3; k++) begin
      a[k]  = wint_t'($signed(crd[k]));
      e1[k] = wint_t'($signed(crd[3+k])) - a[k];
      e2[k] = wint_t'($signed(crd[6+k])) - a[k];
      tv[k] = wint_t'($signed(ray_org[k])) - a[k];
      d[k]  = wint_t'($signed(ray_dir[k]));
    end
    pv[0] = d[1]*e2[2] - d[2]*e2[1];
    pv[1] = d[2]*e2[0] - d[0]*e2[2];
    pv[2] = d[0]*e2[1] - d[1]*e2[0];
    det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
    hi = wint_t'(epsilon_r) <<< 32;
    lo = (wint_t'(1) <<< 32) - hi;
    // Near-zero determinant, measured in Q16.16 after dropping 32 bits.
    if (det == 0) return 0;
    if (det >= lo && det < hi) return 0;
    un = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
    qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
    qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
    qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
    vn = d[0]*qv[0] + d[1]*qv[1] + d[2]*qv[2];
    tn = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (un < 0 || un > det) return 0;
    if (vn < 0 || un + vn > det) return 0;
    if (tn < 0) return 0;
    tq = (tn <<< 16) / det;
    if (tq <= wint_t'(epsilon_r)) return 0;
    if (tq > wint_t'(rtnh_pkg::T_MAX)) tq = wint_t'(rtnh_pkg::T_MAX);
    t_o = tq[30:0];
    u_o = 17'((un <<< 16) / det);
    v_o = 17'((vn <<< 16) / det);
    return 1;
  endfunction

  task automatic clear_search();
    best_valid = 0; best_t = '0; best_u = '0; best_v = '0; best_face = '0; face_count = '0;
  endtask

  // Advance the shadow state by one accepted item and queue any result.
  task automatic track_item(input ray_item_t it);
    logic [30:0] t;
    logic [16:0] u, v;
    hit_result_t r;
    if (it.cmd == rtnh_pkg::CMD_ORG || it.cmd == rtnh_pkg::CMD_DIR) begin
      for (int k = 0; k < 3; k++)
        if (it.cmd == rtnh_pkg::CMD_ORG) ray_org[k] = it.crd[k];
        else ray_dir[k] = it.crd[k];
    end else if (it.cmd == rtnh_pkg::CMD_TRI) begin
      if (!(early_exit_r && best_valid) && triangle_hit(it.crd, t, u, v)) begin
        // A tie keeps the earlier triangle.
        if (!best_valid || t < best_t) begin
          best_valid = 1; best_t = t; best_u = u; best_v = v; best_face = face_count;
        end
      end
      face_count++;
      if (it.last) begin
        r.hit      = best_valid;
        r.hit_dist = best_valid ? best_t : '0;
        r.u        = best_valid ? best_u : '0;
        r.v        = best_valid ? best_v : '0;
        r.face     = best_valid ? best_face : '0;
        nearest_hits.push_back(r);
        clear_search();
      end
    end
  endtask

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin : monitor
    hit_result_t got, want;
    if (!rst && s_tvalid && s_tready) begin
      track_item('{cmd: s_tuser, last: s_tlast, crd: s_tdata});
      in_taken = 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      out_taken = 1;
      got = '{hit: m_tdata[0], hit_dist: m_tdata[31:1], u: m_tdata[48:32],
              v: m_tdata[65:49], face: m_tdata[81:66]};
      if (nearest_hits.size() == 0) begin
        report("unexpected item, hit", 32'(got.hit), 32'd0);
      end else begin
        want = nearest_hits.pop_front();
        if (got.hit != want.hit) report("hit", 32'(got.hit), 32'(want.hit));
        if (got.hit_dist != want.hit_dist)
          report("hit_distance", 32'(got.hit_dist), 32'(want.hit_dist));
        if (got.u != want.u) report("bary_u", 32'(got.u), 32'(want.u));
        if (got.v != want.v) report("bary_v", 32'(got.v), 32'(want.v));
        if (got.face != want.face) report("hit_face", 32'(got.face), 32'(want.face));
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sender: each item waits a random gap before it is offered.
  always @(negedge clk) begin : driver
    logic vld;
    ray_item_t it;
    vld = s_tvalid;
    if (!rst) begin
      if (s_tvalid && in_taken) begin
        vld = 0;
        gap_left = draw_wait();
      end
      in_taken = 0;
      if (!vld && pending_items.size() > 0) begin
        if (gap_left == 0) begin
          it = pending_items.pop_front();
          s_tdata <= it.crd;
          s_tuser <= it.cmd;
          s_tlast <= it.last;
          vld = 1;
        end else begin
          gap_left--;
        end
      end
      s_tvalid <= vld;
    end
  end

  // Receiver: after each item it stalls a random number of cycles.
  always @(negedge clk) begin : receiver
    if (!rst) begin
      if (out_taken) stall_left = draw_wait();
      out_taken = 0;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic put(input logic [1:0] cmd, input coord9_t c, input logic last);
    ray_item_t it;
    it.cmd = cmd;
    it.last = last;
    for (int k = 0; k < 9; k++) it.crd[k] = c[k];
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rtnh_pkg::CFG_EARLY) early_exit_r = val[0];
    else epsilon_r = val;
  endtask

  function automatic int srand(input int mag);
    return $urandom_range(0, 2 * mag) - mag;
  endfunction

  // One ray with a few triangles built around points on it, so hits are common.
  task automatic random_ray(inout int count);
    int o[3], d[3], p[3], n, ks;
    int r1, r2, r3, r4, r5;
    coord9_t c;
    for (int k = 0; k < 3; k++) o[k] = srand(8 << 16);
    d[0] = srand(1 << 15);
    d[1] = srand(1 << 15);
    d[2] = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1 << 16, 2 << 16);
    put(rtnh_pkg::CMD_ORG, '{o[0], o[1], o[2], 0, 0, 0, 0, 0, 0}, 1'($urandom_range(0, 1)));
    put(rtnh_pkg::CMD_DIR, '{d[0], d[1], d[2], 0, 0, 0, 0, 0, 0}, 1'($urandom_range(0, 1)));
    n = $urandom_range(1, 5);
    count += 2 + n;
    for (int i = 0; i < n; i++) begin
      ks = $urandom_range(0, 4);
      for (int k = 0; k < 3; k++) p[k] = o[k] + d[k] * ks;
      r1 = $urandom_range(1 << 14, 3 << 16); r2 = $urandom_range(1 << 14, 3 << 16);
      r3 = $urandom_range(1 << 14, 3 << 16); r4 = $urandom_range(1 << 14, 3 << 16);
      r5 = $urandom_range(1 << 14, 3 << 16);
      c = '{p[0] - r1 + srand(1 << 14), p[1] - r2, p[2] + srand(1 << 15),
            p[0] + r3, p[1] - r4 + srand(1 << 14), p[2] + srand(1 << 15),
            p[0] + srand(1 << 15), p[1] + r5, p[2] + srand(1 << 15)};
      // An occasional mid-stream direction change or dropped marker breaks the pattern.
      if ($urandom_range(0, 19) == 0) begin
        put(rtnh_pkg::CMD_DIR, '{srand(2 << 16), srand(2 << 16), srand(2 << 16),
                                 0, 0, 0, 0, 0, 0}, 1'b0);
        count++;
      end
      put(rtnh_pkg::CMD_TRI, c, (i == n - 1) ? ($urandom_range(0, 15) != 0) : 1'b0);
    end
  endtask

  task automatic noise_item();
    coord9_t c;
    for (int k = 0; k < 9; k++) c[k] = $urandom();
    put(2'($urandom_range(0, 3)), c, 1'($urandom_range(0, 1)));
  endtask

  localparam int ONE = 1 << 16;

  initial begin : stimulus
    int count;
    for (int k = 0; k < 3; k++) begin
      ray_org[k] = '0; ray_dir[k] = '0;
    end
    clear_search();
    early_exit_r = 0;
    epsilon_r = 16'd1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      // Registers change only while the block is idle.
      case (phase)
        1: begin
          write_reg(rtnh_pkg::CFG_EARLY, 16'd0); write_reg(rtnh_pkg::CFG_EPS, 16'd0);
        end
        2: begin
          write_reg(rtnh_pkg::CFG_EARLY, 16'd1); write_reg(rtnh_pkg::CFG_EPS, 16'd1);
        end
        3: begin
          write_reg(rtnh_pkg::CFG_EARLY, 16'd0); write_reg(rtnh_pkg::CFG_EPS, 16'hFFFF);
        end
        4: begin
          write_reg(rtnh_pkg::CFG_EARLY, 16'd1);
          write_reg(rtnh_pkg::CFG_EPS, 16'($urandom_range(0, 65535)));
        end
        5: begin
          write_reg(rtnh_pkg::CFG_EARLY, 16'd0); write_reg(rtnh_pkg::CFG_EPS, 16'd1);
        end
        default: ;
      endcase
      calm = (phase == 2);
      count = 0;
      if (phase == 0) begin
        // Ray from z = -10 along +z; last_face on loads is ignored.
        put(rtnh_pkg::CMD_ORG, '{0, 0, -10 * ONE, 0, 0, 0, 0, 0, 0}, 1'b1);
        put(rtnh_pkg::CMD_DIR, '{0, 0, ONE, 0, 0, 0, 0, 0, 0}, 1'b1);
        put(rtnh_pkg::CMD_TRI, '{-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0}, 1'b0);
        // Nearer hit, then an equal-distance one that must not replace it.
        put(rtnh_pkg::CMD_TRI, '{-ONE, -ONE, -5 * ONE, ONE, -ONE, -5 * ONE,
                                 0, ONE, -5 * ONE}, 1'b0);
        put(rtnh_pkg::CMD_TRI, '{-ONE, -ONE, -5 * ONE, 0, ONE, -5 * ONE,
                                 ONE, -ONE, -5 * ONE}, 1'b0);
        // Behind the origin, degenerate, two off to the side, a dropped command, and too close.
        put(rtnh_pkg::CMD_TRI, '{-ONE, -ONE, -20 * ONE, ONE, -ONE, -20 * ONE,
                                 0, ONE, -20 * ONE}, 1'b0);
        put(rtnh_pkg::CMD_TRI, '{ONE, ONE, 0, ONE, ONE, 0, ONE, ONE, 0}, 1'b0);
        put(rtnh_pkg::CMD_TRI, '{5 * ONE, -ONE, 0, 7 * ONE, -ONE, 0, 6 * ONE, ONE, 0}, 1'b0);
        put(rtnh_pkg::CMD_TRI, '{-ONE, 0, 0, 0, -ONE, 0, -ONE, -ONE, 0}, 1'b0);
        put(rtnh_pkg::CMD_NOP, '{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 1'b1);
        put(rtnh_pkg::CMD_TRI, '{-ONE, -ONE, -10 * ONE + 1, ONE, -ONE, -10 * ONE + 1,
                                 0, ONE, -10 * ONE + 1}, 1'b1);
        // Field extremes, then a ray with nothing to hit.
        put(rtnh_pkg::CMD_TRI, '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                 32'h7FFFFFFF, 32'h80000000, -1, 0, 32'h7FFFFFFF}, 1'b1);
        put(rtnh_pkg::CMD_ORG, '{-1, -1, -1, 0, 0, 0, 0, 0, 0}, 1'b0);
        put(rtnh_pkg::CMD_DIR, '{32'h80000000, 32'h80000000, 32'h80000000,
                                 0, 0, 0, 0, 0, 0}, 1'b0);
        put(rtnh_pkg::CMD_TRI, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1);
        put(rtnh_pkg::CMD_TRI, '{32'h80000000, 32'h7FFFFFFF, 0, 0, 32'h80000000, 32'h7FFFFFFF,
                                 32'h7FFFFFFF, 0, 32'h80000000}, 1'b1);
      end
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          noise_item();
          count++;
        end else begin
          random_ray(count);
        end
      end
      // The sender holds off until every expected result is back.
      while (pending_items.size() > 0 || s_tvalid || nearest_hits.size() > 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
